// File: design/dsc_pkg.sv
package dsc_pkg;

    localparam int DSC_DICT_BYTES   = 4096;
    localparam int DSC_MAX_WORD_LEN = 32;

    localparam logic [1:0] REQ_DICT = 2'd0;
    localparam logic [1:0] REQ_ART  = 2'd1;
    localparam logic [1:0] REQ_END  = 2'd2;

    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_UP_A = 8'h41;
    localparam logic [7:0] CH_UP_Z = 8'h5A;
    localparam logic [7:0] CH_LO_A = 8'h61;
    localparam logic [7:0] CH_LO_Z = 8'h7A;
    localparam logic [7:0] CH_CASE = CH_LO_A - CH_UP_A;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
        logic       too_long;
    } t_out_word;

    typedef struct packed {
        logic accept;
        logic scan_start;
        logic scan_run;
        logic emit_start;
        logic emit_rd;
        logic emit_next;
        logic clear_word;
    } t_cmd;

    typedef struct packed {
        logic ends_word;
        logic in_word;
        logic overflow;
        logic long_enough;
        logic scan_done;
        logic found;
        logic emit_last;
    } t_status;

    function automatic logic is_letter(input logic [7:0] b);
        return (b inside {[CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z]});
    endfunction

    function automatic logic [7:0] fold_upper(input logic [7:0] b);
        if (b inside {[CH_LO_A:CH_LO_Z]}) begin
            return b - CH_CASE;
        end
        return b;
    endfunction

endpackage

// File: design/dsc_ram.sv
module dsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/dsc_ctrl.sv
module dsc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  dsc_pkg::t_status i_status,
    output dsc_pkg::t_cmd    o_cmd
);
    import dsc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT_RD,
        S_EMIT_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_in_stall, r_out_valid;
    t_cmd   cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    if (i_status.ends_word) begin
                        if (i_status.in_word && i_status.overflow) begin
                            cmd.emit_start = 1'b1;
                            n_state        = S_EMIT_RD;
                        end else if (i_status.in_word && i_status.long_enough) begin
                            cmd.scan_start = 1'b1;
                            n_state        = S_SCAN;
                        end else begin
                            cmd.clear_word = 1'b1;
                        end
                    end
                end
            end
            S_SCAN: begin
                cmd.scan_run = 1'b1;
                if (i_status.scan_done) begin
                    if (i_status.found) begin
                        cmd.clear_word = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        cmd.emit_start = 1'b1;
                        n_state        = S_EMIT_RD;
                    end
                end
            end
            S_EMIT_RD: begin
                cmd.emit_rd = 1'b1;
                n_state     = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (!i_out_stall) begin
                    if (i_status.emit_last) begin
                        cmd.clear_word = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        cmd.emit_next = 1'b1;
                        n_state       = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_stall  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_stall  <= (n_state != S_IDLE);
            r_out_valid <= (n_state == S_EMIT_OUT);
        end
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;

endmodule

// File: design/dsc_datapath.sv
module dsc_datapath #(
    parameter int DICT_BYTES   = dsc_pkg::DSC_DICT_BYTES,
    parameter int MAX_WORD_LEN = dsc_pkg::DSC_MAX_WORD_LEN
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dsc_pkg::t_in_word  i_in_word,
    input  dsc_pkg::t_cmd      i_cmd,
    output dsc_pkg::t_status   o_status,
    output dsc_pkg::t_out_word o_out_word
);
    import dsc_pkg::*;

    localparam int DLW = $clog2(DICT_BYTES + 1);
    localparam int DAW = $clog2(DICT_BYTES);
    localparam int CW  = $clog2(MAX_WORD_LEN + 1);
    localparam int AW  = $clog2(MAX_WORD_LEN);
    localparam int PW  = $clog2(MAX_WORD_LEN + 2);

    logic [DLW-1:0] r_len;
    logic [CW-1:0]  r_count;
    logic           r_in_word, r_over;
    logic [DLW-1:0] r_idx;
    logic           r_rvld;
    logic [PW-1:0]  r_pos, n_pos;
    logic           r_same, n_same;
    logic [AW-1:0]  r_k;

    logic [7:0]     dict_q, word_q;
    logic           dict_we, word_we, dict_re;
    logic           match_now, end_now;
    logic [7:0]     b;

    assign b = i_in_word.char_byte;

    assign dict_we = i_cmd.accept && (i_in_word.req_type == REQ_DICT) && (b != 8'd0)
                     && (r_len < DLW'(DICT_BYTES));
    assign word_we = i_cmd.accept && (i_in_word.req_type == REQ_ART) && is_letter(b)
                     && (r_count < CW'(MAX_WORD_LEN));
    assign dict_re = i_cmd.scan_run && (r_idx < r_len);

    // One dictionary byte per cycle; the buffer byte for its position is
    // fetched alongside it, using the position that follows the byte in flight.
    always_comb begin
        n_pos     = r_pos;
        n_same    = r_same;
        match_now = 1'b0;
        if (r_rvld) begin
            if (dict_q == CH_NL) begin
                match_now = r_same && (r_pos == PW'(r_count));
                n_pos     = '0;
                n_same    = 1'b1;
            end else begin
                if (!((r_pos < PW'(r_count)) && (fold_upper(dict_q) == fold_upper(word_q)))) begin
                    n_same = 1'b0;
                end
                if (r_pos != PW'(MAX_WORD_LEN + 1)) begin
                    n_pos = r_pos + PW'(1);
                end
            end
        end
    end

    assign end_now = (r_idx == r_len) && !r_rvld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_count   <= '0;
            r_in_word <= 1'b0;
            r_over    <= 1'b0;
            r_rvld    <= 1'b0;
        end else begin
            if (dict_we) begin
                r_len <= r_len + DLW'(1);
            end
            if (i_cmd.accept && (i_in_word.req_type == REQ_ART) && is_letter(b)) begin
                r_in_word <= 1'b1;
                if (r_count < CW'(MAX_WORD_LEN)) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_over <= 1'b1;
                end
            end
            if (i_cmd.clear_word) begin
                r_count   <= '0;
                r_in_word <= 1'b0;
                r_over    <= 1'b0;
            end
            r_rvld <= dict_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_idx  <= '0;
            r_pos  <= '0;
            r_same <= 1'b1;
        end else if (i_cmd.scan_run) begin
            r_pos  <= n_pos;
            r_same <= n_same;
            if (dict_re) begin
                r_idx <= r_idx + DLW'(1);
            end
        end
        if (i_cmd.emit_start) begin
            r_k <= '0;
        end else if (i_cmd.emit_next) begin
            r_k <= r_k + AW'(1);
        end
    end

    dsc_ram #(
        .WIDTH(8),
        .DEPTH(DICT_BYTES)
    ) u_dict_ram (
        .i_clk  (i_clk),
        .i_we   (dict_we),
        .i_waddr(r_len[DAW-1:0]),
        .i_wdata(b),
        .i_re   (dict_re),
        .i_raddr(r_idx[DAW-1:0]),
        .o_rdata(dict_q)
    );

    dsc_ram #(
        .WIDTH(8),
        .DEPTH(MAX_WORD_LEN)
    ) u_word_ram (
        .i_clk  (i_clk),
        .i_we   (word_we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(b),
        .i_re   (i_cmd.scan_run || i_cmd.emit_rd),
        .i_raddr(i_cmd.emit_rd ? r_k : n_pos[AW-1:0]),
        .o_rdata(word_q)
    );

    assign o_status.ends_word   = ((i_in_word.req_type == REQ_ART) && !is_letter(b))
                                  || (i_in_word.req_type == REQ_END);
    assign o_status.in_word     = r_in_word;
    assign o_status.overflow    = r_over;
    assign o_status.long_enough = (r_count >= CW'(2));
    assign o_status.scan_done   = match_now || end_now;
    assign o_status.found       = match_now || (end_now && r_same && (r_pos == PW'(r_count)));
    assign o_status.emit_last   = ((CW'(r_k) + CW'(1)) == r_count);

    assign o_out_word.out_char = word_q;
    assign o_out_word.last     = o_status.emit_last;
    assign o_out_word.too_long = r_over;

endmodule

// File: design/dictionary_spell_checker.sv
// Case-insensitive dictionary spell checker. Each input word carries a request
// type and a byte: dictionary bytes (newline-separated words) are appended to a
// DICT_BYTES store, and bytes past its capacity or equal to zero are dropped.
// Article bytes are split into runs of ASCII letters; a run ends at any
// non-letter article byte or at an end-of-article request. A run of two or more
// letters is looked up by scanning the dictionary store once from the start,
// one byte per cycle through the store's single read port, stopping early at
// the first match. A run that is not found comes out one character per output
// word in its original case, with last set on its final character; each
// character is read from the word store and then held until the output side
// takes it. A run longer than MAX_WORD_LEN letters is cut to that length,
// skips the lookup and is reported with too_long set. Bytes that do not end
// a word never stall the input side. While a word is being looked up or
// reported, the input side is stalled. There is no clearing pass after reset.
module dictionary_spell_checker #(
    parameter int DICT_BYTES   = dsc_pkg::DSC_DICT_BYTES,
    parameter int MAX_WORD_LEN = dsc_pkg::DSC_MAX_WORD_LEN
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dsc_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dsc_pkg::t_out_word o_out_word
);
    import dsc_pkg::*;

    // Commands flow from the controller to the datapath, status flows back.
    t_cmd    cmd;
    t_status status;

    dsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath holds both stores, the word counters and the compare logic.
    dsc_datapath #(
        .DICT_BYTES  (DICT_BYTES),
        .MAX_WORD_LEN(MAX_WORD_LEN)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_word (i_in_word),
        .i_cmd     (cmd),
        .o_status  (status),
        .o_out_word(o_out_word)
    );

`ifndef NO_ASSERTIONS
    // No new input word is taken while a reported character is pending.
    a_no_accept_during_output: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall
    ) else $error("input accepted while an output word is pending");

    // Delivering the final character of a word returns the block to idle.
    a_last_returns_idle: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_word.last) |=> (!o_in_stall && !o_out_valid)
    ) else $error("block did not return to idle after the last character");

    // Output words are only produced after the input side has been stalled.
    a_output_after_stall: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall)
    ) else $error("output word appeared without a lookup or report phase");
`endif

endmodule

// File: verif/tb_dictionary_spell_checker.sv
`timescale 1ns / 1ps

module tb_dictionary_spell_checker;

    import dsc_pkg::*;

    // The request code that the block has no use for; it must be taken and ignored.
    localparam logic [1:0] REQ_SPARE = 2'd3;

    // Longest run of cycles without any handshake before the run is declared hung.
    // The slowest legal stretch is one full scan of the store or the quiet time
    // at the end, both far below this.
    localparam int IDLE_LIMIT = 20000;

    // Tracks the dictionary and the pending article word, and keeps the
    // characters of misspelled words that the block still owes.
    class spell_scoreboard;
        logic [7:0] lexicon[DSC_DICT_BYTES];
        int         lexicon_len;
        logic [7:0] word_buf[DSC_MAX_WORD_LEN];
        int         word_len;
        bit         word_open;
        bit         word_cut;
        t_out_word  owed_chars[$];
        int         errors;
        int         words_in;
        int         results_seen;
        int         words_closed;
        int         words_flagged;

        static function bit alpha(logic [7:0] b);
            return (b >= CH_UP_A && b <= CH_UP_Z) || (b >= CH_LO_A && b <= CH_LO_Z);
        endfunction

        static function logic [7:0] caps(logic [7:0] b);
            if (b >= CH_LO_A && b <= CH_LO_Z) begin
                return b - CH_CASE;
            end
            return b;
        endfunction

        // Ends the pending word, scans the dictionary for it and queues its
        // characters when it is misspelled or was cut short.
        function void close_word();
            bit flagged;
            bit same;
            int pos;
            flagged = 1'b0;
            if (word_open) begin
                words_closed++;
                if (word_cut) begin
                    flagged = 1'b1;
                end else if (word_len >= 2) begin
                    flagged = 1'b1;
                    same    = 1'b1;
                    pos     = 0;
                    for (int i = 0; i < lexicon_len && flagged; i++) begin
                        if (lexicon[i] == CH_NL) begin
                            if (same && pos == word_len) flagged = 1'b0;
                            pos  = 0;
                            same = 1'b1;
                        end else begin
                            if (pos >= word_len || caps(lexicon[i]) != caps(word_buf[pos])) begin
                                same = 1'b0;
                            end
                            pos++;
                        end
                    end
                    // The last stored word may lack its closing newline.
                    if (flagged && same && pos == word_len) flagged = 1'b0;
                end
            end
            if (flagged) begin
                words_flagged++;
                for (int k = 0; k < word_len; k++) begin
                    owed_chars.push_back(t_out_word'{out_char: word_buf[k],
                                                     last:     (k + 1 == word_len),
                                                     too_long: word_cut});
                end
            end
            word_open = 1'b0;
            word_cut  = 1'b0;
            word_len  = 0;
        endfunction

        function void note_input(t_in_word w);
            words_in++;
            case (w.req_type)
                REQ_DICT: begin
                    if (w.char_byte != 8'h00 && lexicon_len < DSC_DICT_BYTES) begin
                        lexicon[lexicon_len] = w.char_byte;
                        lexicon_len++;
                    end
                end
                REQ_ART: begin
                    if (alpha(w.char_byte)) begin
                        word_open = 1'b1;
                        if (word_len < DSC_MAX_WORD_LEN) begin
                            word_buf[word_len] = w.char_byte;
                            word_len++;
                        end else begin
                            word_cut = 1'b1;
                        end
                    end else begin
                        close_word();
                    end
                end
                REQ_END: begin
                    close_word();
                end
                default: begin
                end
            endcase
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40) $display("[%0t] ERROR %s", $time, what);
        endtask

        task check_result(t_out_word got);
            t_out_word want;
            results_seen++;
            if (owed_chars.size() == 0) begin
                report($sformatf("result with nothing owed: char %02h last %0b too_long %0b",
                                 got.out_char, got.last, got.too_long));
                return;
            end
            want = owed_chars.pop_front();
            if (got.out_char !== want.out_char || got.last !== want.last ||
                got.too_long !== want.too_long) begin
                report($sformatf("result %0d: got %02h/%0b/%0b, want %02h/%0b/%0b (char/last/too_long)",
                                 results_seen, got.out_char, got.last, got.too_long,
                                 want.out_char, want.last, want.too_long));
            end
        endtask
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_in_word   i_in_word   = '0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_word  o_out_word;

    spell_scoreboard sb;

    int    idle_cycles;
    int    burst_left;
    int    items_sent;
    int    stall_left;
    bit    stall_on;
    string vocab[$];

    dictionary_spell_checker u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // All handshakes are observed in one place, with the values that stood
    // before the edge, so that predictions never race the result checks.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) sb.note_input(i_in_word);
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_word);
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
    end

    // The output side passes through free-running stretches and stall
    // stretches of random lengths, independent of what the block is doing.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_on   = ($urandom_range(0, 2) == 0);
            stall_left = stall_on ? $urandom_range(1, 6) : $urandom_range(1, 20);
        end else begin
            stall_left--;
        end
        i_out_stall <= stall_on;
    end

    initial begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("Timeout: no word moved in %0d cycles.", IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Offers one word and returns at the edge where it is taken. The sender
    // works in bursts; between bursts valid drops for a random gap, and some
    // bursts follow each other with no gap at all.
    task automatic send(input logic [1:0] kind, input logic [7:0] ch);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= t_in_word'{req_type: kind, char_byte: ch};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        burst_left--;
        if (kind != REQ_SPARE) items_sent++;
    endtask

    task automatic send_text(input logic [1:0] kind, input string s);
        for (int i = 0; i < s.len(); i++) send(kind, s[i]);
    endtask

    function automatic string rand_word(int n);
        string      s;
        logic [7:0] c;
        s = "";
        repeat (n) begin
            c = 8'(CH_UP_A + $urandom_range(0, 25));
            if ($urandom_range(0, 1)) c = c + CH_CASE;
            s = $sformatf("%s%c", s, c);
        end
        return s;
    endfunction

    function automatic logic [7:0] rand_gap_byte();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (spell_scoreboard::alpha(c));
        return c;
    endfunction

    initial begin : stimulus
        string      w;
        int         pick;
        int         stop_at;
        logic [7:0] odd;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. An end of article with nothing pending and the spare
        // request code must both pass without any result.
        send(REQ_END, 8'hFF);
        send(REQ_SPARE, "Z");
        // A zero byte inside a dictionary word is dropped, so this stores "Cat".
        // The extra newline makes an empty line that must match nothing.
        send_text(REQ_DICT, "Ca");
        send(REQ_DICT, 8'h00);
        send_text(REQ_DICT, "t\n\n");
        // Found in another case; a zero article byte ends the word.
        send_text(REQ_ART, "cAT");
        send(REQ_ART, 8'h00);
        // A dictionary byte arriving mid-word must not disturb the word, and
        // 0xFF ends it; "Dog" is unknown and comes back whole.
        send_text(REQ_ART, "Do");
        send(REQ_DICT, 8'hFF);
        send_text(REQ_ART, "g");
        send(REQ_ART, 8'hFF);
        // A single letter is never reported.
        send_text(REQ_ART, "z");
        send(REQ_END, 8'h00);
        // One letter past the buffer: the first 32 come back marked too long.
        send_text(REQ_ART, "AbCdEfGhIjKlMnOpQrStUvWxYzAbCdEfG");
        send(REQ_END, 8'h5A);
        send_text(REQ_ART, "zz");
        send(REQ_END, 8'h00);

        // Random part. Most of it is a mix of dictionary words and article words
        // that often hit them, sometimes in another case or off by one letter; the
        // rest is raw noise on the dictionary and spare request codes.
        stop_at = items_sent + 80;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                w = rand_word($urandom_range(1, 7));
                if ($urandom_range(0, 7) == 0) begin
                    odd = 8'($urandom_range(1, 255));
                    w   = $sformatf("%s%c%s", w, odd, rand_word($urandom_range(0, 2)));
                end else begin
                    vocab.push_back(w);
                end
                send_text(REQ_DICT, {w, "\n"});
            end else if (pick < 25) begin
                send(REQ_DICT, 8'($urandom_range(0, 255)));
            end else if (pick < 30) begin
                send(REQ_SPARE, 8'($urandom_range(0, 255)));
            end else begin
                if (vocab.size() != 0 && $urandom_range(0, 9) < 6) begin
                    w = vocab[$urandom_range(0, vocab.size() - 1)];
                    for (int i = 0; i < w.len(); i++) begin
                        if ($urandom_range(0, 1)) w[i] = w[i] ^ CH_CASE;
                    end
                    case ($urandom_range(0, 7))
                        0: if (w.len() >= 2) w = w.substr(0, w.len() - 2);
                        1: w = {w, rand_word(1)};
                        default: begin
                        end
                    endcase
                end else if ($urandom_range(0, 9) == 0) begin
                    w = rand_word($urandom_range(30, 36));
                end else begin
                    w = rand_word($urandom_range(1, 8));
                end
                send_text(REQ_ART, w);
                if ($urandom_range(0, 4) == 0) begin
                    send(REQ_END, 8'($urandom_range(0, 255)));
                end else begin
                    send(REQ_ART, rand_gap_byte());
                end
            end
        end
        send(REQ_END, 8'h00);
        i_in_valid <= 1'b0;

        // Wait for every owed character, then give the block time for one
        // more full scan in case it still produces something it should not.
        while (sb.owed_chars.size() != 0) @(posedge i_clk);
        repeat (DSC_DICT_BYTES + 200) @(posedge i_clk);
        if (sb.owed_chars.size() != 0) begin
            sb.report($sformatf("%0d characters never arrived", sb.owed_chars.size()));
        end

        $display("Run covered %0d input words, %0d dictionary bytes kept, %0d article words closed.",
                 sb.words_in, sb.lexicon_len, sb.words_closed);
        $display("%0d words came back as misspelled, %0d result words checked, %0d errors.",
                 sb.words_flagged, sb.results_seen, sb.errors);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
